@@ hdl/iqpu_pkg.sv @@
// ----------------------------------------------------------------------------
// iqpu_pkg: shared types and constants of the quadrature phase unwrap tracker
// Widths, fixed-point constants, control word layout and the microcode
// program of the sequencer.
// ----------------------------------------------------------------------------
package iqpu_pkg;

   // field widths
   localparam int SAMPLE_BITS  = 16;
   localparam int TURN_BITS    = 24;
   localparam int PHASE_BITS   = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int COEF_BITS    = 16;
   localparam int DIST_BITS    = 32;
   localparam int CSR_IDX_W    = 1;

   // fixed-point layout
   localparam int SMOOTH_FRAC  = 7;
   localparam int PRESCALE_SH  = 8;
   localparam int CORDIC_W     = SAMPLE_BITS + PRESCALE_SH + 4;
   localparam int ANGLE_W      = 34;
   localparam int ANGLE_SH     = 32 - PHASE_BITS;
   localparam int RQ_W         = ANGLE_W - ANGLE_SH;
   localparam int FRAC_W       = PHASE_BITS + 1;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int ATAN_IDX_W   = 5;
   localparam int TOTAL_W      = TURN_BITS + PHASE_BITS + 1;
   localparam int SMOOTH_W     = TOTAL_W + SMOOTH_FRAC;
   localparam int DIFF_W       = SMOOTH_W + 1;
   localparam int CHUNK_W      = 16;
   localparam int MUL_W        = CHUNK_W + 1;
   localparam int PROD_W       = 2 * MUL_W;
   localparam int ACC_W        = 64;
   localparam int EMIT_SH      = PHASE_BITS + SMOOTH_FRAC;
   localparam int EP_W         = ACC_W - EMIT_SH;
   localparam int PC_W         = 5;

   // reset values of the control registers
   localparam logic [COEF_BITS-1:0] ALPHA_RESET = COEF_BITS'(1311);
   localparam logic [COEF_BITS-1:0] UM_RESET    = COEF_BITS'(4250);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH_ALPHA = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_UM_PER_TURN  = 1'b1;

   // rounding and clamp constants
   localparam logic signed [ANGLE_W-1:0] HALF_TURN_ANGLE = ANGLE_W'(64'h8000_0000);
   localparam logic signed [ANGLE_W-1:0] ROUND_ANGLE     = ANGLE_W'(2 ** (ANGLE_SH - 1));
   localparam logic signed [RQ_W-1:0]    FRAC_HI_Q       = RQ_W'(2 ** (PHASE_BITS - 1));
   localparam logic signed [RQ_W-1:0]    FRAC_LO_Q       = RQ_W'(1 - 2 ** (PHASE_BITS - 1));
   localparam logic signed [DIFF_W-1:0]  DIFF_MAX = {2'b00, {(SMOOTH_W - 1){1'b1}}};
   localparam logic signed [DIFF_W-1:0]  DIFF_MIN = {2'b11, {(SMOOTH_W - 2){1'b0}}, 1'b1};
   localparam logic signed [ACC_W-1:0]   EMIT_ROUND = ACC_W'(2 ** (EMIT_SH - 1));
   localparam logic signed [EP_W-1:0]    DIST_MAX = {{(EP_W - DIST_BITS + 1){1'b0}},
                                                     {(DIST_BITS - 1){1'b1}}};
   localparam logic signed [EP_W-1:0]    DIST_MIN = {{(EP_W - DIST_BITS + 1){1'b1}},
                                                     {(DIST_BITS - 1){1'b0}}};
   localparam logic [STEP_W-1:0]         STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

   // datapath operations
   typedef enum logic [3:0] {
      OP_NOP    = 4'd0,
      OP_ACCEPT = 4'd1,
      OP_PREP   = 4'd2,
      OP_ROT    = 4'd3,
      OP_FRAC   = 4'd4,
      OP_SDIFF  = 4'd5,
      OP_MAC    = 4'd6,
      OP_SMOOTH = 4'd7,
      OP_EDIFF  = 4'd8,
      OP_ZERO   = 4'd9,
      OP_EMIT   = 4'd10
   } op_type;

   // multiplier operand chunk of the difference register
   typedef enum logic [1:0] {
      CH_LO  = 2'd0,
      CH_MID = 2'd1,
      CH_HI  = 2'd2
   } chunk_type;

   // accumulator action
   typedef enum logic [1:0] {
      ACC_CLR  = 2'd0,
      ACC_SH32 = 2'd1,
      ACC_SH16 = 2'd2,
      ACC_SH0  = 2'd3
   } accm_type;

   // coefficient select
   typedef enum logic {
      COEF_ALPHA = 1'b0,
      COEF_UM    = 1'b1
   } coef_type;

   // sequencer jump conditions
   typedef enum logic [2:0] {
      J_NEXT   = 3'd0,
      J_GOTO   = 3'd1,
      J_LOOP   = 3'd2,
      J_ACCEPT = 3'd3,
      J_EMIT   = 3'd4
   } jmp_type;

   typedef struct packed {
      op_type            op;
      chunk_type         chunk;
      accm_type          accm;
      coef_type          coef;
      jmp_type           jmp;
      logic [PC_W-1:0]   target;
   } ucode_type;

   // program addresses
   localparam logic [PC_W-1:0] PC_ACCEPT   = 5'd0;
   localparam logic [PC_W-1:0] PC_PREP     = 5'd1;
   localparam logic [PC_W-1:0] PC_ROT      = 5'd2;
   localparam logic [PC_W-1:0] PC_FRAC     = 5'd3;
   localparam logic [PC_W-1:0] PC_SDIFF    = 5'd4;
   localparam logic [PC_W-1:0] PC_SMAC_HI  = 5'd5;
   localparam logic [PC_W-1:0] PC_SMAC_MID = 5'd6;
   localparam logic [PC_W-1:0] PC_SMAC_LO  = 5'd7;
   localparam logic [PC_W-1:0] PC_SMAC_SUM = 5'd8;
   localparam logic [PC_W-1:0] PC_SMOOTH   = 5'd9;
   localparam logic [PC_W-1:0] PC_EDIFF    = 5'd10;
   localparam logic [PC_W-1:0] PC_EMAC_HI  = 5'd11;
   localparam logic [PC_W-1:0] PC_EMAC_MID = 5'd12;
   localparam logic [PC_W-1:0] PC_EMAC_LO  = 5'd13;
   localparam logic [PC_W-1:0] PC_EMAC_SUM = 5'd14;
   localparam logic [PC_W-1:0] PC_EMIT     = 5'd15;
   localparam logic [PC_W-1:0] PC_ZERO     = 5'd16;

   // plain control word with default multiplier fields and the given jump
   function automatic ucode_type uc_word(input op_type op, input jmp_type jmp,
                                         input logic [PC_W-1:0] target);
      ucode_type w;
      w.op     = op;
      w.chunk  = CH_LO;
      w.accm   = ACC_CLR;
      w.coef   = COEF_ALPHA;
      w.jmp    = jmp;
      w.target = target;
      return w;
   endfunction

   // one multiply-accumulate step
   function automatic ucode_type uc_mac(input chunk_type chunk, input accm_type accm,
                                        input coef_type coef);
      ucode_type w;
      w.op     = OP_MAC;
      w.chunk  = chunk;
      w.accm   = accm;
      w.coef   = coef;
      w.jmp    = J_NEXT;
      w.target = PC_ACCEPT;
      return w;
   endfunction

   // microcode program
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         PC_ACCEPT:   w = uc_word(OP_ACCEPT, J_ACCEPT, PC_ZERO);
         PC_PREP:     w = uc_word(OP_PREP, J_NEXT, PC_ACCEPT);
         PC_ROT:      w = uc_word(OP_ROT, J_LOOP, PC_ROT);
         PC_FRAC:     w = uc_word(OP_FRAC, J_NEXT, PC_ACCEPT);
         PC_SDIFF:    w = uc_word(OP_SDIFF, J_NEXT, PC_ACCEPT);
         PC_SMAC_HI:  w = uc_mac(CH_HI, ACC_CLR, COEF_ALPHA);
         PC_SMAC_MID: w = uc_mac(CH_MID, ACC_SH32, COEF_ALPHA);
         PC_SMAC_LO:  w = uc_mac(CH_LO, ACC_SH16, COEF_ALPHA);
         PC_SMAC_SUM: w = uc_mac(CH_LO, ACC_SH0, COEF_ALPHA);
         PC_SMOOTH:   w = uc_word(OP_SMOOTH, J_NEXT, PC_ACCEPT);
         PC_EDIFF:    w = uc_word(OP_EDIFF, J_NEXT, PC_ACCEPT);
         PC_EMAC_HI:  w = uc_mac(CH_HI, ACC_CLR, COEF_UM);
         PC_EMAC_MID: w = uc_mac(CH_MID, ACC_SH32, COEF_UM);
         PC_EMAC_LO:  w = uc_mac(CH_LO, ACC_SH16, COEF_UM);
         PC_EMAC_SUM: w = uc_mac(CH_LO, ACC_SH0, COEF_UM);
         PC_EMIT:     w = uc_word(OP_EMIT, J_EMIT, PC_ACCEPT);
         PC_ZERO:     w = uc_word(OP_ZERO, J_GOTO, PC_EDIFF);
         default:     w = uc_word(OP_NOP, J_GOTO, PC_ACCEPT);
      endcase
      return w;
   endfunction

   // arctangent of 2^-k in 1/2^32 turn
   function automatic logic [31:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic [31:0] a;
      case (idx)
         5'd0:    a = 32'h20000000;
         5'd1:    a = 32'h12E4051D;
         5'd2:    a = 32'h09FB385B;
         5'd3:    a = 32'h051111D4;
         5'd4:    a = 32'h028B0D43;
         5'd5:    a = 32'h0145D7E1;
         5'd6:    a = 32'h00A2F61E;
         5'd7:    a = 32'h00517C55;
         5'd8:    a = 32'h0028BE53;
         5'd9:    a = 32'h00145F2E;
         5'd10:   a = 32'h000A2F98;
         5'd11:   a = 32'h000517CC;
         5'd12:   a = 32'h00028BE6;
         5'd13:   a = 32'h000145F3;
         5'd14:   a = 32'h0000A2F9;
         5'd15:   a = 32'h0000517C;
         5'd16:   a = 32'h000028BE;
         5'd17:   a = 32'h0000145F;
         5'd18:   a = 32'h00000A2F;
         5'd19:   a = 32'h00000517;
         5'd20:   a = 32'h0000028B;
         5'd21:   a = 32'h00000145;
         5'd22:   a = 32'h000000A2;
         5'd23:   a = 32'h00000051;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

@@ hdl/iq_phase_unwrap_tracker.sv @@
// ----------------------------------------------------------------------------
// iq_phase_unwrap_tracker: quadrature phase unwrap with smoothed distance
// Centres offset-binary I/Q samples, takes their phase with a CORDIC,
// counts whole turns, smooths the unwrapped phase and reports a distance.
// ----------------------------------------------------------------------------
// A sample transaction runs through the microcoded sequencer from acceptance
// to its result, and the next one can be accepted in the same cycle that
// result is first offered; a zero command runs a shorter sequence. The
// sequence is 16 iterations of one shared CORDIC rotator, then two passes
// of high, middle and low chunk products and their sum through a single
// 17x17 multiplier (smoothing update and distance scaling). A finished
// result waits in the output register while the next transaction is
// accepted. Configuration writes take effect at once.
module iq_phase_unwrap_tracker (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_ready,
   input  logic                                         req_func,
   input  logic        [iqpu_pkg::SAMPLE_BITS-1:0]      req_i_sample,
   input  logic        [iqpu_pkg::SAMPLE_BITS-1:0]      req_q_sample,
   output logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   output logic signed [iqpu_pkg::DIST_BITS-1:0]        rsp_distance_um,
   output logic signed [iqpu_pkg::TURN_BITS-1:0]        rsp_turn_count,
   output logic signed [iqpu_pkg::PHASE_BITS-1:0]       rsp_phase_fraction,
   input  logic                                         csr_write_en,
   input  logic        [iqpu_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic        [iqpu_pkg::COEF_BITS-1:0]        csr_wdata
);

   // sequencer
   logic [iqpu_pkg::PC_W-1:0]               pc_ff, pc_in;
   iqpu_pkg::ucode_type                     uc;
   logic                                    emit_go;

   // configuration
   logic [iqpu_pkg::COEF_BITS-1:0]          alpha_ff, alpha_in;
   logic [iqpu_pkg::COEF_BITS-1:0]          um_ff, um_in;

   // tracker state
   logic signed [iqpu_pkg::TURN_BITS-1:0]   turns_ff, turns_in;
   logic                                    prevq_ff, prevq_in;
   logic [iqpu_pkg::PHASE_BITS-1:0]         last_ff, last_in;
   logic [iqpu_pkg::PHASE_BITS-1:0]         ref_ff, ref_in;
   logic signed [iqpu_pkg::SMOOTH_W-1:0]    s_ff, s_in;

   // datapath registers
   logic [iqpu_pkg::SAMPLE_BITS-1:0]        i_ff, i_in;
   logic [iqpu_pkg::SAMPLE_BITS-1:0]        q_ff, q_in;
   logic signed [iqpu_pkg::CORDIC_W-1:0]    x_ff, x_in;
   logic signed [iqpu_pkg::CORDIC_W-1:0]    y_ff, y_in;
   logic signed [iqpu_pkg::ANGLE_W-1:0]     z_ff, z_in;
   logic [iqpu_pkg::STEP_W-1:0]             k_ff, k_in;
   logic                                    zvec_ff, zvec_in;
   logic signed [iqpu_pkg::FRAC_W-1:0]      frac_ff, frac_in;
   logic signed [iqpu_pkg::SMOOTH_W-1:0]    diff_ff, diff_in;
   logic signed [iqpu_pkg::PROD_W-1:0]      prod_ff, prod_in;
   logic signed [iqpu_pkg::ACC_W-1:0]       acc_ff, acc_in;

   // result register
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic signed [iqpu_pkg::DIST_BITS-1:0]   dist_ff, dist_in;
   logic signed [iqpu_pkg::TURN_BITS-1:0]   rturn_ff, rturn_in;
   logic [iqpu_pkg::PHASE_BITS-1:0]         rfrac_ff, rfrac_in;

   // combinational helpers
   logic signed [iqpu_pkg::SAMPLE_BITS-1:0] i_c, q_c;
   logic signed [iqpu_pkg::CORDIC_W-1:0]    x0, y0, dx, dy;
   logic signed [iqpu_pkg::ANGLE_W-1:0]     ang, rz;
   logic signed [iqpu_pkg::RQ_W-1:0]        rq;
   logic signed [iqpu_pkg::FRAC_W-1:0]      frac_c;
   logic signed [iqpu_pkg::TOTAL_W-1:0]     total;
   logic signed [iqpu_pkg::SMOOTH_W-1:0]    t_sc;
   logic signed [iqpu_pkg::MUL_W-1:0]       mop, cop;
   logic signed [iqpu_pkg::ACC_W-1:0]       er;
   logic signed [iqpu_pkg::EP_W-1:0]        ep;

   // clamp a difference to the symmetric 48-bit range
   function automatic logic signed [iqpu_pkg::SMOOTH_W-1:0] clamp_diff(
      input logic signed [iqpu_pkg::DIFF_W-1:0] v);
      logic signed [iqpu_pkg::SMOOTH_W-1:0] r;
      if (v > iqpu_pkg::DIFF_MAX) begin
         r = iqpu_pkg::DIFF_MAX[iqpu_pkg::SMOOTH_W-1:0];
      end else if (v < iqpu_pkg::DIFF_MIN) begin
         r = iqpu_pkg::DIFF_MIN[iqpu_pkg::SMOOTH_W-1:0];
      end else begin
         r = v[iqpu_pkg::SMOOTH_W-1:0];
      end
      return r;
   endfunction

   // stored fraction to signed value, the half-turn code reads as +1/2
   function automatic logic signed [iqpu_pkg::FRAC_W-1:0] decode_frac(
      input logic [iqpu_pkg::PHASE_BITS-1:0] f);
      logic signed [iqpu_pkg::FRAC_W-1:0] r;
      if (f == {1'b1, {(iqpu_pkg::PHASE_BITS - 1){1'b0}}}) begin
         r = $signed({1'b0, f});
      end else begin
         r = $signed({f[iqpu_pkg::PHASE_BITS-1], f});
      end
      return r;
   endfunction

   // fraction scaled into the smoothing format
   function automatic logic signed [iqpu_pkg::SMOOTH_W-1:0] scale_frac(
      input logic signed [iqpu_pkg::FRAC_W-1:0] v);
      return iqpu_pkg::SMOOTH_W'(v) <<< iqpu_pkg::SMOOTH_FRAC;
   endfunction

   // control word fetch and handshake
   assign uc        = iqpu_pkg::ucode_rom(pc_ff);
   assign req_ready = (uc.op == iqpu_pkg::OP_ACCEPT);
   assign emit_go   = (uc.op == iqpu_pkg::OP_EMIT) && (!rsp_valid_ff || rsp_ready);

   // step counter and jumps
   always_comb begin
      case (uc.jmp)
         iqpu_pkg::J_NEXT:   pc_in = pc_ff + 1'b1;
         iqpu_pkg::J_GOTO:   pc_in = uc.target;
         iqpu_pkg::J_LOOP:   pc_in = (k_ff != iqpu_pkg::STEP_LAST) ? uc.target : pc_ff + 1'b1;
         iqpu_pkg::J_ACCEPT: pc_in = req_valid ? (req_func ? uc.target : pc_ff + 1'b1) : pc_ff;
         iqpu_pkg::J_EMIT:   pc_in = emit_go ? uc.target : pc_ff;
         default:            pc_in = iqpu_pkg::PC_ACCEPT;
      endcase
   end

   // configuration writes
   always_comb begin
      alpha_in = alpha_ff;
      um_in    = um_ff;
      if (csr_write_en) begin
         case (csr_index)
            iqpu_pkg::CSR_SMOOTH_ALPHA: alpha_in = csr_wdata;
            iqpu_pkg::CSR_UM_PER_TURN:  um_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   // centred samples and cordic start vector
   assign i_c = $signed({~i_ff[iqpu_pkg::SAMPLE_BITS-1], i_ff[iqpu_pkg::SAMPLE_BITS-2:0]});
   assign q_c = $signed({~q_ff[iqpu_pkg::SAMPLE_BITS-1], q_ff[iqpu_pkg::SAMPLE_BITS-2:0]});
   assign x0  = iqpu_pkg::CORDIC_W'(i_c) <<< iqpu_pkg::PRESCALE_SH;
   assign y0  = iqpu_pkg::CORDIC_W'(q_c) <<< iqpu_pkg::PRESCALE_SH;

   // rotator terms
   assign dx  = y_ff >>> k_ff;
   assign dy  = x_ff >>> k_ff;
   assign ang = $signed({{(iqpu_pkg::ANGLE_W - 32){1'b0}},
                         iqpu_pkg::atan_entry(iqpu_pkg::ATAN_IDX_W'(k_ff))});

   // angle rounding to the phase resolution with clamp
   assign rz = z_ff + iqpu_pkg::ROUND_ANGLE;
   assign rq = $signed(rz[iqpu_pkg::ANGLE_W-1:iqpu_pkg::ANGLE_SH]);
   always_comb begin
      if (zvec_ff) begin
         frac_c = '0;
      end else if (rq > iqpu_pkg::FRAC_HI_Q) begin
         frac_c = iqpu_pkg::FRAC_HI_Q[iqpu_pkg::FRAC_W-1:0];
      end else if (rq < iqpu_pkg::FRAC_LO_Q) begin
         frac_c = iqpu_pkg::FRAC_LO_Q[iqpu_pkg::FRAC_W-1:0];
      end else begin
         frac_c = rq[iqpu_pkg::FRAC_W-1:0];
      end
   end

   // unwrapped phase in smoothing format
   assign total = iqpu_pkg::TOTAL_W'($signed({turns_ff, {iqpu_pkg::PHASE_BITS{1'b0}}}))
                + iqpu_pkg::TOTAL_W'(frac_ff);
   assign t_sc  = iqpu_pkg::SMOOTH_W'(total) <<< iqpu_pkg::SMOOTH_FRAC;

   // multiplier operands
   always_comb begin
      case (uc.chunk)
         iqpu_pkg::CH_HI:  mop = $signed({diff_ff[iqpu_pkg::SMOOTH_W-1],
                                          diff_ff[iqpu_pkg::SMOOTH_W-1:2*iqpu_pkg::CHUNK_W]});
         iqpu_pkg::CH_MID: mop = $signed({1'b0,
                                          diff_ff[2*iqpu_pkg::CHUNK_W-1:iqpu_pkg::CHUNK_W]});
         default:          mop = $signed({1'b0, diff_ff[iqpu_pkg::CHUNK_W-1:0]});
      endcase
      cop = (uc.coef == iqpu_pkg::COEF_UM) ? $signed({1'b0, um_ff}) : $signed({1'b0, alpha_ff});
   end

   // distance rounding
   assign er = acc_ff + iqpu_pkg::EMIT_ROUND;
   assign ep = $signed(er[iqpu_pkg::ACC_W-1:iqpu_pkg::EMIT_SH]);

   // datapath next state
   always_comb begin
      i_in     = i_ff;
      q_in     = q_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      k_in     = k_ff;
      zvec_in  = zvec_ff;
      frac_in  = frac_ff;
      diff_in  = diff_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      turns_in = turns_ff;
      prevq_in = prevq_ff;
      last_in  = last_ff;
      ref_in   = ref_ff;
      s_in     = s_ff;
      dist_in  = dist_ff;
      rturn_in = rturn_ff;
      rfrac_in = rfrac_ff;
      case (uc.op)
         // capture the transaction
         iqpu_pkg::OP_ACCEPT: begin
            i_in = req_i_sample;
            q_in = req_q_sample;
         end
         // turn counting and cordic setup
         iqpu_pkg::OP_PREP: begin
            if (!q_c[iqpu_pkg::SAMPLE_BITS-1] && prevq_ff && i_c[iqpu_pkg::SAMPLE_BITS-1]) begin
               turns_in = turns_ff - iqpu_pkg::TURN_BITS'(1);
            end
            if (q_c[iqpu_pkg::SAMPLE_BITS-1] && !prevq_ff && i_c[iqpu_pkg::SAMPLE_BITS-1]) begin
               turns_in = turns_ff + iqpu_pkg::TURN_BITS'(1);
            end
            prevq_in = q_c[iqpu_pkg::SAMPLE_BITS-1];
            zvec_in  = (i_c == '0) && (q_c == '0);
            k_in     = '0;
            if (i_c[iqpu_pkg::SAMPLE_BITS-1]) begin
               x_in = -x0;
               y_in = -y0;
               z_in = q_c[iqpu_pkg::SAMPLE_BITS-1] ? -iqpu_pkg::HALF_TURN_ANGLE
                                                   : iqpu_pkg::HALF_TURN_ANGLE;
            end else begin
               x_in = x0;
               y_in = y0;
               z_in = '0;
            end
         end
         // one vectoring iteration
         iqpu_pkg::OP_ROT: begin
            if (!y_ff[iqpu_pkg::CORDIC_W-1]) begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + ang;
            end else begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - ang;
            end
            k_in = k_ff + 1'b1;
         end
         // phase fraction
         iqpu_pkg::OP_FRAC: begin
            frac_in = frac_c;
            last_in = frac_c[iqpu_pkg::PHASE_BITS-1:0];
         end
         // smoothing error
         iqpu_pkg::OP_SDIFF: begin
            diff_in = clamp_diff(iqpu_pkg::DIFF_W'(t_sc) - iqpu_pkg::DIFF_W'(s_ff));
         end
         // chunked multiply-accumulate
         iqpu_pkg::OP_MAC: begin
            prod_in = mop * cop;
            case (uc.accm)
               iqpu_pkg::ACC_CLR:  acc_in = '0;
               iqpu_pkg::ACC_SH32: acc_in = acc_ff + (iqpu_pkg::ACC_W'(prod_ff)
                                                      <<< (2 * iqpu_pkg::CHUNK_W));
               iqpu_pkg::ACC_SH16: acc_in = acc_ff + (iqpu_pkg::ACC_W'(prod_ff)
                                                      <<< iqpu_pkg::CHUNK_W);
               default:            acc_in = acc_ff + iqpu_pkg::ACC_W'(prod_ff);
            endcase
         end
         // smoothed phase update, floor of product over 2^16
         iqpu_pkg::OP_SMOOTH: begin
            s_in = s_ff + $signed(acc_ff[iqpu_pkg::ACC_W-1:iqpu_pkg::CHUNK_W]);
         end
         // distance error against the reference
         iqpu_pkg::OP_EDIFF: begin
            diff_in = clamp_diff(iqpu_pkg::DIFF_W'(scale_frac(decode_frac(ref_ff)))
                                 - iqpu_pkg::DIFF_W'(s_ff));
         end
         // zero command: re-reference
         iqpu_pkg::OP_ZERO: begin
            turns_in = '0;
            ref_in   = last_ff;
            s_in     = scale_frac(decode_frac(last_ff));
         end
         // load the result register
         iqpu_pkg::OP_EMIT: begin
            if (emit_go) begin
               if (ep > iqpu_pkg::DIST_MAX) begin
                  dist_in = iqpu_pkg::DIST_MAX[iqpu_pkg::DIST_BITS-1:0];
               end else if (ep < iqpu_pkg::DIST_MIN) begin
                  dist_in = iqpu_pkg::DIST_MIN[iqpu_pkg::DIST_BITS-1:0];
               end else begin
                  dist_in = ep[iqpu_pkg::DIST_BITS-1:0];
               end
               rturn_in = turns_ff;
               rfrac_in = last_ff;
            end
         end
         default: ;
      endcase
   end

   // result valid
   assign rsp_valid_in = emit_go || (rsp_valid_ff && !rsp_ready);

   // control and tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= iqpu_pkg::PC_ACCEPT;
         rsp_valid_ff <= 1'b0;
         alpha_ff     <= iqpu_pkg::ALPHA_RESET;
         um_ff        <= iqpu_pkg::UM_RESET;
         turns_ff     <= '0;
         prevq_ff     <= 1'b0;
         last_ff      <= '0;
         ref_ff       <= '0;
         s_ff         <= '0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         alpha_ff     <= alpha_in;
         um_ff        <= um_in;
         turns_ff     <= turns_in;
         prevq_ff     <= prevq_in;
         last_ff      <= last_in;
         ref_ff       <= ref_in;
         s_ff         <= s_in;
      end
   end

   // datapath and result payload
   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      q_ff     <= q_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      k_ff     <= k_in;
      zvec_ff  <= zvec_in;
      frac_ff  <= frac_in;
      diff_ff  <= diff_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      dist_ff  <= dist_in;
      rturn_ff <= rturn_in;
      rfrac_ff <= rfrac_in;
   end

   // outputs
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_distance_um    = dist_ff;
   assign rsp_turn_count     = rturn_ff;
   assign rsp_phase_fraction = $signed(rfrac_ff);

endmodule

@@ hdl/iqpu_checker.sv @@
// ----------------------------------------------------------------------------
// iqpu_checker: port-level checks of the phase unwrap tracker
// Watches handshakes and result timing on the top-level ports.
// ----------------------------------------------------------------------------
module iqpu_checker (
   input logic                                         clock,
   input logic                                         reset,
   input logic                                         req_valid,
   input logic                                         req_ready,
   input logic                                         req_func,
   input logic                                         rsp_valid,
   input logic                                         rsp_ready,
   input logic signed [iqpu_pkg::DIST_BITS-1:0]        rsp_distance_um,
   input logic signed [iqpu_pkg::TURN_BITS-1:0]        rsp_turn_count,
   input logic signed [iqpu_pkg::PHASE_BITS-1:0]       rsp_phase_fraction
);

   localparam int ZERO_LAT   = 8;
   localparam int SAMPLE_LAT = iqpu_pkg::CORDIC_STEPS + 15;

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance_um)
         && $stable(rsp_turn_count) && $stable(rsp_phase_fraction))
      else $error("result changed while stalled");

   // reset leaves no result and the input open
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

   // one transaction in flight
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("input accepted while busy");

   // zero command gives a zero result when the output was free
   a_zero: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_func && !rsp_valid |-> ##ZERO_LAT
         rsp_valid && (rsp_distance_um == '0) && (rsp_turn_count == '0))
      else $error("zero command result wrong or late");

   // sample gives a result when the output was free
   a_sample: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_func && !rsp_valid |-> ##SAMPLE_LAT rsp_valid)
      else $error("sample result late");

endmodule

bind iq_phase_unwrap_tracker iqpu_checker u_iqpu_checker (.*);
